### rtl/xst_pkg.sv
// ---------------------------------------------------------------------------
// xst_pkg
// Shared types, constants and character helpers for the XML subset checker.
// ---------------------------------------------------------------------------
package xst_pkg;

    localparam int MAX_DEPTH  = 16;
    localparam int NAME_BYTES = 32;
    localparam int MAX_ATTRS  = 8;

    localparam int DEPTH_W    = $clog2(MAX_DEPTH + 1);
    localparam int LEVEL_W    = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;
    localparam int LEN_W      = $clog2(NAME_BYTES + 1);
    localparam int IDX_W      = (NAME_BYTES > 1) ? $clog2(NAME_BYTES) : 1;
    localparam int CNT_W      = $clog2(MAX_ATTRS + 1);
    localparam int SLOTS      = MAX_DEPTH * MAX_ATTRS;
    localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int OPEN_BYTES = MAX_DEPTH * NAME_BYTES;
    localparam int OPEN_AW    = (OPEN_BYTES > 1) ? $clog2(OPEN_BYTES) : 1;
    localparam int ATTR_BYTES = SLOTS * NAME_BYTES;
    localparam int ATTR_AW    = (ATTR_BYTES > 1) ? $clog2(ATTR_BYTES) : 1;

    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    typedef enum logic [3:0] {
        PH_EXPECT, PH_LT, PH_SNAME, PH_ENAME, PH_AFTER_END, PH_ATTRS, PH_ANAME,
        PH_EQ, PH_QUOTE, PH_VALUE, PH_AFTER_VALUE, PH_CLOSE, PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_OK, ST_DONE, ST_TOKEN, ST_DUP, ST_MISMATCH, ST_JUNK, ST_TRUNC, ST_CAP
    } status_t;

    typedef enum logic [1:0] {
        EV_NONE, EV_OPEN, EV_ATTR, EV_CLOSE
    } event_t;

    typedef enum logic [1:0] {
        OP_NONE, OP_SOPEN, OP_ECLOSE, OP_ATTR
    } op_t;

    typedef enum logic [1:0] {
        RES_OK, RES_DUP, RES_MISMATCH, RES_CAP
    } res_t;

    typedef enum logic [3:0] {
        SQ_IDLE, SQ_LEN_RD, SQ_LEN_CK, SQ_BYTE_RD, SQ_BYTE_CK, SQ_CAP_CK,
        SQ_COPY_RD, SQ_COPY_WR, SQ_DONE
    } sq_state_t;

    typedef struct packed {
        logic                 start;
        op_t                  op;
        logic [DEPTH_W-1:0]   depth;
        logic [CNT_W-1:0]     count;
        logic [LEN_W-1:0]     cur_len;
        logic [LEN_W-1:0]     open_len;
        logic                 wr_en;
        logic [IDX_W-1:0]     wr_idx;
        logic [7:0]           wr_data;
    } req_t;

    typedef struct packed {
        logic done;
        res_t res;
    } resp_t;

    function automatic logic is_ws(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_namech(input logic [7:0] c);
        return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
               (c >= 8'h61 && c <= 8'h7A);
    endfunction

endpackage

### rtl/xml_subset_tag_checker.sv
// ---------------------------------------------------------------------------
// xml_subset_tag_checker
// Byte-stream checker for a small XML subset with tag matching.
// ---------------------------------------------------------------------------
// One result per transaction. A byte that ends a name runs the shared byte
// comparator over the name stores, each step a read and then a check, because
// every store has one registered read port: a start tag or attribute name
// walks the stored parent attributes, comparing bytes on an equal length,
// then runs the capacity check, copies the name byte by byte and finishes;
// an end tag name compares byte by byte and finishes, or goes straight to
// the finish when the lengths differ. A duplicate, mismatch or capacity hit
// ends the walk early. The result is registered from the comparator's done
// state. Input is held off while such a byte is in work, and while a result
// waits in the output register under a stall.
// ---------------------------------------------------------------------------
module xml_subset_tag_checker import xst_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [7:0]  byte_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  event_res,
    output logic [2:0]  status,
    output logic [4:0]  nesting_depth,
    output logic [31:0] line_number,
    output logic [31:0] column_number
);

    phase_t             phase_reg, phase_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic [DEPTH_W-1:0] depth_reg, depth_next;
    status_t            sticky_reg, sticky_next;
    logic [31:0]        line_reg, line_next, col_reg, col_next;
    logic               busy_reg, busy_next;
    op_t                op_reg, op_next;
    logic [7:0]         c_reg, c_next;
    logic               out_valid_reg, out_valid_next;
    event_t             ev_reg, ev_next;
    status_t            st_reg, st_next;
    logic [4:0]         odep_reg, odep_next;
    logic [31:0]        oline_reg, oline_next, ocol_reg, ocol_next;

    logic [CNT_W-1:0]   cnt_reg [MAX_DEPTH];
    logic [LEN_W-1:0]   olen_reg [MAX_DEPTH];
    logic               cnt_clr, cnt_inc, cnt_clr_all, olen_we;

    logic [LEVEL_W-1:0] lv, top_lv;
    logic [DEPTH_W-1:0] dec_depth;
    logic               in_accept;
    status_t            f_st;
    event_t             f_ev;
    op_t                f_op;
    req_t               req;
    resp_t              resp;

    assign lv        = LEVEL_W'(depth_reg - DEPTH_W'(1));
    assign top_lv    = LEVEL_W'(depth_reg);
    assign dec_depth = (depth_reg != '0) ? DEPTH_W'(depth_reg - DEPTH_W'(1)) : depth_reg;
    assign in_stall  = busy_reg || (out_valid_reg && out_stall);
    assign in_accept = in_valid && !in_stall;

    xst_seq u_seq (
        .clk(clk), .rst_n(rst_n), .req(req), .resp(resp)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_EXPECT;
            len_reg       <= '0;
            depth_reg     <= '0;
            sticky_reg    <= ST_OK;
            line_reg      <= 32'd1;
            col_reg       <= 32'd1;
            busy_reg      <= 1'b0;
            op_reg        <= OP_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            len_reg       <= len_next;
            depth_reg     <= depth_next;
            sticky_reg    <= sticky_next;
            line_reg      <= line_next;
            col_reg       <= col_next;
            busy_reg      <= busy_next;
            op_reg        <= op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg     <= c_next;
        ev_reg    <= ev_next;
        st_reg    <= st_next;
        odep_reg  <= odep_next;
        oline_reg <= oline_next;
        ocol_reg  <= ocol_next;
        if (olen_we)
        begin
            olen_reg[top_lv] <= len_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int n = 0; n < MAX_DEPTH; n++)
            begin
                cnt_reg[n] <= '0;
            end
        end
        else if (cnt_clr_all)
        begin
            for (int n = 0; n < MAX_DEPTH; n++)
            begin
                cnt_reg[n] <= '0;
            end
        end
        else
        begin
            if (cnt_clr)
            begin
                cnt_reg[top_lv] <= '0;
            end
            if (cnt_inc)
            begin
                cnt_reg[lv] <= CNT_W'(cnt_reg[lv] + CNT_W'(1));
            end
        end
    end

    // Next state: parse phase, counters, output register and requests
    // to the comparator.
    always_comb
    begin
        phase_next     = phase_reg;
        len_next       = len_reg;
        depth_next     = depth_reg;
        sticky_next    = sticky_reg;
        line_next      = line_reg;
        col_next       = col_reg;
        busy_next      = busy_reg;
        op_next        = op_reg;
        c_next         = c_reg;
        out_valid_next = out_valid_reg && out_stall;
        ev_next        = ev_reg;
        st_next        = st_reg;
        odep_next      = odep_reg;
        oline_next     = oline_reg;
        ocol_next      = ocol_reg;
        cnt_clr        = 1'b0;
        cnt_inc        = 1'b0;
        cnt_clr_all    = 1'b0;
        olen_we        = 1'b0;
        f_st           = ST_OK;
        f_ev           = EV_NONE;
        f_op           = OP_NONE;
        req.start      = 1'b0;
        req.op         = OP_NONE;
        req.depth      = depth_reg;
        req.count      = cnt_reg[lv];
        req.cur_len    = len_reg;
        req.open_len   = olen_reg[lv];
        req.wr_en      = 1'b0;
        req.wr_idx     = IDX_W'(len_reg);
        req.wr_data    = byte_value;

        if (busy_reg)
        begin
            if (resp.done)
            begin
                busy_next = 1'b0;
                case (resp.res)
                    RES_DUP:      f_st = ST_DUP;
                    RES_MISMATCH: f_st = ST_MISMATCH;
                    RES_CAP:      f_st = ST_CAP;
                    default:
                    begin
                        case (op_reg)
                            OP_SOPEN:
                            begin
                                olen_we    = 1'b1;
                                cnt_clr    = 1'b1;
                                depth_next = DEPTH_W'(depth_reg + DEPTH_W'(1));
                                f_ev       = EV_OPEN;
                                if (is_ws(c_reg))
                                    phase_next = PH_ATTRS;
                                else if (c_reg == CH_SLASH)
                                    phase_next = PH_CLOSE;
                                else
                                    phase_next = PH_EXPECT;
                            end
                            OP_ECLOSE:
                            begin
                                if (is_ws(c_reg))
                                begin
                                    phase_next = PH_AFTER_END;
                                end
                                else
                                begin
                                    depth_next = dec_depth;
                                    f_ev       = EV_CLOSE;
                                    phase_next = (dec_depth == '0) ? PH_DONE : PH_EXPECT;
                                end
                            end
                            default:
                            begin
                                cnt_inc    = 1'b1;
                                phase_next = is_ws(c_reg) ? PH_EQ : PH_QUOTE;
                            end
                        endcase
                    end
                endcase
                if (f_st != ST_OK)
                begin
                    sticky_next = f_st;
                    f_ev        = EV_NONE;
                end
                out_valid_next = 1'b1;
                ev_next        = f_ev;
                st_next        = f_st;
                odep_next      = 5'(depth_next);
            end
        end
        else if (in_accept)
        begin
            oline_next = line_reg;
            ocol_next  = col_reg;
            if (byte_value == CH_LF)
            begin
                if (line_reg != 32'hFFFF_FFFF)
                    line_next = line_reg + 32'd1;
                col_next = 32'd1;
            end
            else if (col_reg != 32'hFFFF_FFFF)
            begin
                col_next = col_reg + 32'd1;
            end

            if (kind)
            begin
                // End of document: report, then restart everything
                out_valid_next = 1'b1;
                ev_next        = EV_NONE;
                if (sticky_reg != ST_OK)
                    st_next = sticky_reg;
                else
                    st_next = (phase_reg == PH_DONE) ? ST_DONE : ST_TRUNC;
                odep_next   = 5'(depth_reg);
                phase_next  = PH_EXPECT;
                len_next    = '0;
                depth_next  = '0;
                sticky_next = ST_OK;
                line_next   = 32'd1;
                col_next    = 32'd1;
                cnt_clr_all = 1'b1;
            end
            else if (sticky_reg != ST_OK)
            begin
                out_valid_next = 1'b1;
                ev_next        = EV_NONE;
                st_next        = sticky_reg;
                odep_next      = 5'(depth_reg);
            end
            else
            begin
                case (phase_reg)
                    PH_EXPECT:
                    begin
                        if (byte_value == CH_LT)
                            phase_next = PH_LT;
                        else if (!is_ws(byte_value))
                            f_st = ST_TOKEN;
                    end
                    PH_LT:
                    begin
                        len_next = '0;
                        if (byte_value == CH_SLASH)
                        begin
                            if (depth_reg == '0)
                                f_st = ST_TOKEN;
                            else
                                phase_next = PH_ENAME;
                        end
                        else
                        begin
                            phase_next = PH_SNAME;
                            if (is_namech(byte_value))
                            begin
                                req.wr_en  = 1'b1;
                                req.wr_idx = '0;
                                len_next   = LEN_W'(1);
                            end
                            else
                            begin
                                f_st = ST_TOKEN;
                            end
                        end
                    end
                    PH_SNAME, PH_ENAME, PH_ANAME:
                    begin
                        if (is_namech(byte_value))
                        begin
                            if (int'(len_reg) >= NAME_BYTES)
                            begin
                                f_st = ST_CAP;
                            end
                            else
                            begin
                                req.wr_en = 1'b1;
                                len_next  = LEN_W'(len_reg + LEN_W'(1));
                            end
                        end
                        else if (len_reg == '0)
                        begin
                            f_st = ST_TOKEN;
                        end
                        else if (phase_reg == PH_SNAME)
                        begin
                            if (!is_ws(byte_value) && byte_value != CH_SLASH &&
                                byte_value != CH_GT)
                                f_st = ST_TOKEN;
                            else
                                f_op = OP_SOPEN;
                        end
                        else if (phase_reg == PH_ENAME)
                        begin
                            if ((!is_ws(byte_value) && byte_value != CH_GT) ||
                                depth_reg == '0)
                                f_st = ST_TOKEN;
                            else
                                f_op = OP_ECLOSE;
                        end
                        else
                        begin
                            if ((!is_ws(byte_value) && byte_value != CH_EQ) ||
                                depth_reg == '0)
                                f_st = ST_TOKEN;
                            else
                                f_op = OP_ATTR;
                        end
                    end
                    PH_AFTER_END, PH_CLOSE:
                    begin
                        if (phase_reg == PH_AFTER_END && is_ws(byte_value))
                        begin
                            phase_next = PH_AFTER_END;
                        end
                        else if (byte_value != CH_GT)
                        begin
                            f_st = ST_TOKEN;
                        end
                        else
                        begin
                            depth_next = dec_depth;
                            f_ev       = EV_CLOSE;
                            phase_next = (dec_depth == '0) ? PH_DONE : PH_EXPECT;
                        end
                    end
                    PH_ATTRS, PH_AFTER_VALUE:
                    begin
                        if (is_ws(byte_value))
                        begin
                            phase_next = PH_ATTRS;
                        end
                        else if (byte_value == CH_SLASH)
                        begin
                            phase_next = PH_CLOSE;
                        end
                        else if (byte_value == CH_GT)
                        begin
                            phase_next = PH_EXPECT;
                        end
                        else if (phase_reg == PH_AFTER_VALUE)
                        begin
                            f_st = ST_TOKEN;
                        end
                        else
                        begin
                            len_next   = '0;
                            phase_next = PH_ANAME;
                            if (is_namech(byte_value))
                            begin
                                req.wr_en  = 1'b1;
                                req.wr_idx = '0;
                                len_next   = LEN_W'(1);
                            end
                            else
                            begin
                                f_st = ST_TOKEN;
                            end
                        end
                    end
                    PH_EQ:
                    begin
                        if (byte_value == CH_EQ)
                            phase_next = PH_QUOTE;
                        else if (!is_ws(byte_value))
                            f_st = ST_TOKEN;
                    end
                    PH_QUOTE:
                    begin
                        if (byte_value == CH_QUOTE)
                            phase_next = PH_VALUE;
                        else if (!is_ws(byte_value))
                            f_st = ST_TOKEN;
                    end
                    PH_VALUE:
                    begin
                        if (byte_value == CH_QUOTE)
                        begin
                            f_ev       = EV_ATTR;
                            phase_next = PH_AFTER_VALUE;
                        end
                    end
                    PH_DONE:
                    begin
                        if (!is_ws(byte_value))
                            f_st = ST_JUNK;
                    end
                    default:
                    begin
                        f_st = ST_TOKEN;
                    end
                endcase

                if (f_op != OP_NONE)
                begin
                    // Hand the name over to the comparator and hold input
                    busy_next = 1'b1;
                    op_next   = f_op;
                    c_next    = byte_value;
                    req.start = 1'b1;
                    req.op    = f_op;
                end
                else
                begin
                    if (f_st != ST_OK)
                    begin
                        sticky_next = f_st;
                        f_ev        = EV_NONE;
                    end
                    out_valid_next = 1'b1;
                    ev_next        = f_ev;
                    st_next        = f_st;
                    odep_next      = 5'(depth_next);
                end
            end
        end
    end

    always_comb
    begin
        out_valid     = out_valid_reg;
        event_res     = ev_reg;
        status        = st_reg;
        nesting_depth = odep_reg;
        line_number   = oline_reg;
        column_number = ocol_reg;
    end

    a_busy_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> in_stall)
        else $error("input taken while a name operation is in work");

    a_done_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
        resp.done |-> busy_reg)
        else $error("comparator finished with no operation pending");

    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(depth_reg) <= MAX_DEPTH)
        else $error("open element count beyond capacity");

    a_result_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && resp.done) |=> (out_valid && !busy_reg))
        else $error("finished name operation gave no result");

endmodule

### rtl/xst_ram.sv
// ---------------------------------------------------------------------------
// xst_ram
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module xst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/xst_seq.sv
// ---------------------------------------------------------------------------
// xst_seq
// Name stores and the shared byte comparator: attribute clash search,
// end tag compare, capacity check and name copy, stepped one byte at a time.
// ---------------------------------------------------------------------------
module xst_seq import xst_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  req_t  req,
    output resp_t resp
);

    sq_state_t          state_reg, state_next;
    op_t                op_reg, op_next;
    logic [CNT_W-1:0]   k_reg, k_next;
    logic [IDX_W-1:0]   i_reg, i_next;
    res_t               res_reg, res_next;

    logic [LEVEL_W-1:0] lv, dst_lv;
    logic [SLOT_W-1:0]  slot_k, slot_new;
    logic [CNT_W-1:0]   k_inc;
    logic               last_k, last_i, cap;

    logic [7:0]         cur_rdata, open_rdata, attr_rdata, stored_rdata;
    logic [LEN_W-1:0]   len_rdata;
    logic [IDX_W-1:0]   cur_raddr;
    logic [OPEN_AW-1:0] open_raddr, open_waddr;
    logic [ATTR_AW-1:0] attr_raddr, attr_waddr;
    logic [SLOT_W-1:0]  len_raddr, len_waddr;
    logic               open_we, attr_we, len_we;

    assign lv       = LEVEL_W'(req.depth - DEPTH_W'(1));
    assign dst_lv   = LEVEL_W'(req.depth);
    assign slot_k   = SLOT_W'(int'(lv) * MAX_ATTRS + int'(k_reg));
    assign slot_new = SLOT_W'(int'(lv) * MAX_ATTRS + int'(req.count));
    assign k_inc    = CNT_W'(k_reg + CNT_W'(1));
    assign last_k   = (k_inc >= req.count);
    assign last_i   = ((LEN_W'(i_reg) + LEN_W'(1)) == req.cur_len);
    assign cap      = (op_reg == OP_SOPEN) ? (int'(req.depth) >= MAX_DEPTH)
                                           : (int'(req.count) >= MAX_ATTRS);
    assign stored_rdata = (op_reg == OP_ECLOSE) ? open_rdata : attr_rdata;

    xst_ram #(.WIDTH(8), .DEPTH(NAME_BYTES)) u_cur_ram (
        .clk(clk), .we(req.wr_en), .waddr(req.wr_idx), .wdata(req.wr_data),
        .raddr(cur_raddr), .rdata(cur_rdata)
    );

    xst_ram #(.WIDTH(8), .DEPTH(OPEN_BYTES)) u_open_ram (
        .clk(clk), .we(open_we), .waddr(open_waddr), .wdata(cur_rdata),
        .raddr(open_raddr), .rdata(open_rdata)
    );

    xst_ram #(.WIDTH(8), .DEPTH(ATTR_BYTES)) u_attr_ram (
        .clk(clk), .we(attr_we), .waddr(attr_waddr), .wdata(cur_rdata),
        .raddr(attr_raddr), .rdata(attr_rdata)
    );

    xst_ram #(.WIDTH(LEN_W), .DEPTH(SLOTS)) u_len_ram (
        .clk(clk), .we(len_we), .waddr(len_waddr), .wdata(req.cur_len),
        .raddr(len_raddr), .rdata(len_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SQ_IDLE;
            op_reg    <= OP_NONE;
            k_reg     <= '0;
            i_reg     <= '0;
            res_reg   <= RES_OK;
        end
        else
        begin
            state_reg <= state_next;
            op_reg    <= op_next;
            k_reg     <= k_next;
            i_reg     <= i_next;
            res_reg   <= res_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        op_next    = op_reg;
        k_next     = k_reg;
        i_next     = i_reg;
        res_next   = res_reg;
        case (state_reg)
            SQ_IDLE:
            begin
                if (req.start)
                begin
                    op_next  = req.op;
                    k_next   = '0;
                    i_next   = '0;
                    res_next = RES_OK;
                    if (req.op == OP_ECLOSE)
                    begin
                        if (req.open_len != req.cur_len)
                        begin
                            res_next   = RES_MISMATCH;
                            state_next = SQ_DONE;
                        end
                        else
                        begin
                            state_next = SQ_BYTE_RD;
                        end
                    end
                    else if (req.depth != '0 && req.count != '0)
                    begin
                        state_next = SQ_LEN_RD;
                    end
                    else
                    begin
                        state_next = SQ_CAP_CK;
                    end
                end
            end
            SQ_LEN_RD:
            begin
                state_next = SQ_LEN_CK;
            end
            SQ_LEN_CK:
            begin
                if (len_rdata == req.cur_len)
                begin
                    i_next     = '0;
                    state_next = SQ_BYTE_RD;
                end
                else
                begin
                    k_next     = k_inc;
                    state_next = last_k ? SQ_CAP_CK : SQ_LEN_RD;
                end
            end
            SQ_BYTE_RD:
            begin
                state_next = SQ_BYTE_CK;
            end
            SQ_BYTE_CK:
            begin
                if (cur_rdata != stored_rdata)
                begin
                    if (op_reg == OP_ECLOSE)
                    begin
                        res_next   = RES_MISMATCH;
                        state_next = SQ_DONE;
                    end
                    else
                    begin
                        k_next     = k_inc;
                        i_next     = '0;
                        state_next = last_k ? SQ_CAP_CK : SQ_LEN_RD;
                    end
                end
                else if (last_i)
                begin
                    res_next   = (op_reg == OP_ECLOSE) ? RES_OK : RES_DUP;
                    state_next = SQ_DONE;
                end
                else
                begin
                    i_next     = IDX_W'(i_reg + IDX_W'(1));
                    state_next = SQ_BYTE_RD;
                end
            end
            SQ_CAP_CK:
            begin
                if (cap)
                begin
                    res_next   = RES_CAP;
                    state_next = SQ_DONE;
                end
                else
                begin
                    i_next     = '0;
                    state_next = SQ_COPY_RD;
                end
            end
            SQ_COPY_RD:
            begin
                state_next = SQ_COPY_WR;
            end
            SQ_COPY_WR:
            begin
                if (last_i)
                begin
                    state_next = SQ_DONE;
                end
                else
                begin
                    i_next     = IDX_W'(i_reg + IDX_W'(1));
                    state_next = SQ_COPY_RD;
                end
            end
            SQ_DONE:
            begin
                state_next = SQ_IDLE;
            end
            default:
            begin
                state_next = SQ_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cur_raddr  = i_reg;
        len_raddr  = slot_k;
        open_raddr = OPEN_AW'(int'(lv) * NAME_BYTES + int'(i_reg));
        attr_raddr = ATTR_AW'(int'(slot_k) * NAME_BYTES + int'(i_reg));
        open_waddr = OPEN_AW'(int'(dst_lv) * NAME_BYTES + int'(i_reg));
        attr_waddr = ATTR_AW'(int'(slot_new) * NAME_BYTES + int'(i_reg));
        len_waddr  = slot_new;
        open_we    = (state_reg == SQ_COPY_WR) && (op_reg == OP_SOPEN);
        attr_we    = (state_reg == SQ_COPY_WR) && (op_reg == OP_ATTR);
        len_we     = (state_reg == SQ_CAP_CK) && (op_reg == OP_ATTR) && !cap;
        resp.done  = (state_reg == SQ_DONE);
        resp.res   = res_reg;
    end

endmodule
